// ===== design/keyboard_scancode_front_end_assert.svh =====
// Assertion macros shared by the keyboard scancode front end.
// Needs no other file; the clock and the active-low reset are passed in.
`ifndef KEYBOARD_SCANCODE_FRONT_END_ASSERT_SVH
`define KEYBOARD_SCANCODE_FRONT_END_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSFE_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("keyboard front end: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KSFE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("keyboard front end: next-cycle check failed");

`endif

// ===== design/kscfe_pkg.sv =====
// Shared types, codes and layout tables of the keyboard scancode front end.
// Depends on nothing; kscfe_ring, kscfe_xlate and the top level import it.
package kscfe_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 256;
    localparam int KEY_SLOTS            = 128;
    localparam int KEY_W                = $clog2(KEY_SLOTS);
    localparam int CODE_W               = 8;
    localparam int CHAR_W               = 7;
    localparam int ROM_SIZE             = 58;
    localparam int ROM_AW               = $clog2(ROM_SIZE);

    localparam logic CMD_SCANCODE = 1'b0;
    localparam logic CMD_POP      = 1'b1;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    localparam int RELEASE_BIT = 7;

    localparam logic [KEY_W-1:0] LSHIFT_KEY = KEY_W'(8'h2A);
    localparam logic [KEY_W-1:0] RSHIFT_KEY = KEY_W'(8'h36);
    localparam logic [KEY_W-1:0] CTRL_KEY   = KEY_W'(8'h1D);

    typedef struct packed {
        logic empty;
        logic full;
    } ring_status_t;

    localparam logic [7:0] PLAIN_ROM [ROM_SIZE] = '{
        8'h00, 8'h00, "1", "2", "3", "4", "5", "6",
        "7", "8", "9", "0", "-", "=", 8'h08, 8'h00,
        "q", "w", "e", "r", "t", "y", "u", "i",
        "o", "p", "[", "]", 8'h0A, 8'h00, "a", "s",
        "d", "f", "g", "h", "j", "k", "l", ";",
        8'h27, 8'h00, 8'h00, 8'h5C, "z", "x", "c", "v",
        "b", "n", "m", ",", ".", "/", 8'h00, 8'h00,
        8'h00, " "
    };

    localparam logic [7:0] SHIFT_ROM [ROM_SIZE] = '{
        8'h00, 8'h00, "!", "@", "#", "$", "%", "^",
        "&", "*", "(", ")", "_", "+", 8'h08, 8'h00,
        "Q", "W", "E", "R", "T", "Y", "U", "I",
        "O", "P", "{", "}", 8'h0A, 8'h00, "A", "S",
        "D", "F", "G", "H", "J", "K", "L", ":",
        8'h22, 8'h00, 8'h00, "|", "Z", "X", "C", "V",
        "B", "N", "M", "<", ">", "?", 8'h00, 8'h00,
        8'h00, " "
    };

endpackage

// ===== design/kscfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; read data holds while the read enable is low.
module kscfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/kscfe_ring.sv =====
// Ring buffer of scancodes: read and write positions around one code RAM.
// Depends on kscfe_pkg and kscfe_ram.
module kscfe_ring #(
    parameter int BUFFER_DEPTH = kscfe_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                        clk,
    input  logic                        rstn,
    input  logic                        push,
    input  logic                        pop,
    input  logic [kscfe_pkg::CODE_W-1:0] push_code,
    output kscfe_pkg::ring_status_t     status,
    output logic [kscfe_pkg::CODE_W-1:0] pop_code
);

    import kscfe_pkg::*;

    localparam int PTR_W = $clog2(BUFFER_DEPTH);

    logic [PTR_W-1:0] wr_pos_reg, wr_pos_next;
    logic [PTR_W-1:0] rd_pos_reg, rd_pos_next;
    logic [PTR_W-1:0] wr_inc, rd_inc;

    assign wr_inc = (wr_pos_reg == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wr_pos_reg + 1'b1;
    assign rd_inc = (rd_pos_reg == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rd_pos_reg + 1'b1;

    assign status.empty = (rd_pos_reg == wr_pos_reg);
    assign status.full  = (wr_inc == rd_pos_reg);

    // A full buffer drops its oldest code to make room for the new one.
    always_comb begin
        wr_pos_next = wr_pos_reg;
        rd_pos_next = rd_pos_reg;
        if (push) begin
            wr_pos_next = wr_inc;
            if (status.full) begin
                rd_pos_next = rd_inc;
            end
        end else if (pop && !status.empty) begin
            rd_pos_next = rd_inc;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_pos_reg <= '0;
            rd_pos_reg <= '0;
        end else begin
            wr_pos_reg <= wr_pos_next;
            rd_pos_reg <= rd_pos_next;
        end
    end

    kscfe_ram #(
        .WIDTH (CODE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_code_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_pos_reg),
        .wdata (push_code),
        .re    (pop),
        .raddr (rd_pos_reg),
        .rdata (pop_code)
    );

endmodule

// ===== design/kscfe_xlate.sv =====
// Key-to-character translation through the fixed layout tables.
// Depends on kscfe_pkg for the tables and widths.
module kscfe_xlate (
    input  logic [kscfe_pkg::KEY_W-1:0]  key,
    input  logic                         shift,
    input  logic                         ctrl,
    output logic [kscfe_pkg::CHAR_W-1:0] ascii
);

    import kscfe_pkg::*;

    logic [7:0] base;
    logic [7:0] shifted;

    assign base    = PLAIN_ROM[key[ROM_AW-1:0]];
    assign shifted = SHIFT_ROM[key[ROM_AW-1:0]];

    // Control turns letters into control codes and blanks every other key.
    always_comb begin
        ascii = '0;
        if (key < KEY_W'(ROM_SIZE)) begin
            if (ctrl) begin
                if (base inside {["a":"z"]}) begin
                    ascii = CHAR_W'(base[4:0]);
                end
            end else if (shift) begin
                ascii = shifted[CHAR_W-1:0];
            end else begin
                ascii = base[CHAR_W-1:0];
            end
        end
    end

endmodule

// ===== design/keyboard_scancode_front_end.sv =====
// Keyboard scancode front end top level: modifier tracking, result pipeline.
// Depends on kscfe_pkg, kscfe_ring, kscfe_xlate and the assertion header.
//
// The s_ channel carries one request per handshake: tuser selects a scancode
// arrival or a pop, tdata carries the scancode byte. Every request produces
// exactly one result on the m_ channel, in request order.
// An arrival is written into the scancode ring buffer (the oldest code is
// dropped when the buffer is full), updates the shift and control state and
// reports a press with its character or a release. A pop returns the oldest
// buffered code, or sets the empty flag.
// A request passes through the code RAM read stage and then the output register
// before m_tvalid. Throughput is one request per cycle while the m_ side accepts,
// set by the single write and single read port of the code RAM.
// A stalled m_ side holds the output register; one more request is taken
// into the RAM read stage, after which s_tready falls until m_tready returns.
// Reset empties the buffer, releases all keys and clears both valid stages,
// with no clearing pass.
module keyboard_scancode_front_end #(
    parameter int BUFFER_DEPTH = kscfe_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scancode
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [6:0] ascii_char, [14:7] popped_code,
                                   // [15] shift_held, [16] ctrl_held, zero above
    output logic [2:0]  m_tuser    // [1:0] event_kind, [2] buffer_empty
);

    import kscfe_pkg::*;

    `include "keyboard_scancode_front_end_assert.svh"

    logic s_fire, s1_adv, is_arrival, is_release;
    logic [KEY_W-1:0] key;

    logic lshift_reg, lshift_next;
    logic rshift_reg, rshift_next;
    logic ctrl_reg, ctrl_next;
    logic [CHAR_W-1:0] xl_ascii;

    ring_status_t ring_status;
    logic [CODE_W-1:0] ring_code;

    logic              s1_valid_reg, s1_valid_next;
    logic [CHAR_W-1:0] s1_ascii_reg;
    logic [1:0]        s1_kind_reg;
    logic              s1_hit_reg, s1_empty_reg, s1_shift_reg, s1_ctrl_reg;

    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_ascii_reg;
    logic [1:0]        m_kind_reg;
    logic [CODE_W-1:0] m_popped_reg;
    logic              m_empty_reg, m_shift_reg, m_ctrl_reg;

    assign s_tready = !s1_valid_reg || !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);

    assign is_arrival = (s_tuser == CMD_SCANCODE);
    assign is_release = s_tdata[RELEASE_BIT];
    assign key        = s_tdata[KEY_W-1:0];

    always_comb begin
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        ctrl_next   = ctrl_reg;
        if (s_fire && is_arrival) begin
            if (key == LSHIFT_KEY) begin
                lshift_next = !is_release;
            end
            if (key == RSHIFT_KEY) begin
                rshift_next = !is_release;
            end
            if (key == CTRL_KEY) begin
                ctrl_next = !is_release;
            end
        end
    end

    kscfe_xlate u_xlate (
        .key   (key),
        .shift (lshift_next || rshift_next),
        .ctrl  (ctrl_next),
        .ascii (xl_ascii)
    );

    kscfe_ring #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .clk       (aclk),
        .rstn      (aresetn),
        .push      (s_fire && is_arrival),
        .pop       (s_fire && !is_arrival),
        .push_code (s_tdata),
        .status    (ring_status),
        .pop_code  (ring_code)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lshift_reg   <= 1'b0;
            rshift_reg   <= 1'b0;
            ctrl_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            lshift_reg   <= lshift_next;
            rshift_reg   <= rshift_next;
            ctrl_reg     <= ctrl_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_ascii_reg <= (is_arrival && !is_release) ? xl_ascii : '0;
            s1_kind_reg  <= !is_arrival ? EV_NONE : (is_release ? EV_RELEASE : EV_PRESS);
            s1_hit_reg   <= !is_arrival && !ring_status.empty;
            s1_empty_reg <= !is_arrival && ring_status.empty;
            s1_shift_reg <= lshift_next || rshift_next;
            s1_ctrl_reg  <= ctrl_next;
        end
        if (s1_adv) begin
            m_ascii_reg  <= s1_ascii_reg;
            m_kind_reg   <= s1_kind_reg;
            m_popped_reg <= s1_hit_reg ? ring_code : '0;
            m_empty_reg  <= s1_empty_reg;
            m_shift_reg  <= s1_shift_reg;
            m_ctrl_reg   <= s1_ctrl_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_ctrl_reg, m_shift_reg, m_popped_reg, m_ascii_reg};
    assign m_tuser  = {m_empty_reg, m_kind_reg};

    `KSFE_ASSERT_SAME(a_stall_only_when_full, aclk, aresetn,
        !s_tready, s1_valid_reg && m_valid_reg && !m_tready)
    `KSFE_ASSERT_NEXT(a_push_leaves_data, aclk, aresetn,
        s_fire && is_arrival, !ring_status.empty)
    `KSFE_ASSERT_SAME(a_empty_pop_result, aclk, aresetn,
        m_valid_reg && m_empty_reg, m_kind_reg == EV_NONE && m_popped_reg == '0)
    `KSFE_ASSERT_SAME(a_ctrl_char_range, aclk, aresetn,
        m_valid_reg && m_ctrl_reg && m_kind_reg == EV_PRESS,
        m_ascii_reg < CHAR_W'(8'h20))

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the keyboard scancode front end: a queued request driver,
// a result monitor and a scoreboard fed by a built-in key map and ring buffer predictor.
// Depends on kscfe_pkg and keyboard_scancode_front_end from the design folder.
`timescale 1ns / 1ps

module testbench;
    import kscfe_pkg::*;

    localparam int LAYOUT_KEYS = 58;

    localparam logic [7:0] US_LOWER [LAYOUT_KEYS] = '{
        8'h00, 8'h00, "1", "2", "3", "4", "5", "6",
        "7", "8", "9", "0", "-", "=", 8'h08, 8'h00,
        "q", "w", "e", "r", "t", "y", "u", "i",
        "o", "p", "[", "]", 8'h0A, 8'h00, "a", "s",
        "d", "f", "g", "h", "j", "k", "l", ";",
        8'h27, 8'h00, 8'h00, 8'h5C, "z", "x", "c", "v",
        "b", "n", "m", ",", ".", "/", 8'h00, 8'h00,
        8'h00, " "
    };

    localparam logic [7:0] US_UPPER [LAYOUT_KEYS] = '{
        8'h00, 8'h00, "!", "@", "#", "$", "%", "^",
        "&", "*", "(", ")", "_", "+", 8'h08, 8'h00,
        "Q", "W", "E", "R", "T", "Y", "U", "I",
        "O", "P", "{", "}", 8'h0A, 8'h00, "A", "S",
        "D", "F", "G", "H", "J", "K", "L", ":",
        8'h22, 8'h00, 8'h00, "|", "Z", "X", "C", "V",
        "B", "N", "M", "<", ">", "?", 8'h00, 8'h00,
        8'h00, " "
    };

    typedef struct packed {
        logic       cmd;
        logic [7:0] code;
        logic       drain_first;
    } key_request_t;

    typedef struct packed {
        logic [6:0] ascii;
        logic [1:0] kind;
        logic [7:0] popped;
        logic       empty;
        logic       shift;
        logic       ctrl;
    } key_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = CMD_SCANCODE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    key_request_t pending_requests[$];
    key_result_t  awaited_results[$];
    int           mismatches = 0;

    logic [KEY_SLOTS-1:0] keys_down = '0;
    logic [7:0]           ring_codes [256];
    logic [7:0]           ring_wr = '0;
    logic [7:0]           ring_rd = '0;

    int          burst_left = 1;
    int          gap_left   = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age   = 0;

    keyboard_scancode_front_end dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #1_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic logic [6:0] layout_char(input logic [KEY_W-1:0] key);
        logic [7:0] base;
        if (key >= KEY_W'(LAYOUT_KEYS)) begin
            return '0;
        end
        base = US_LOWER[key[ROM_AW-1:0]];
        if (keys_down[CTRL_KEY]) begin
            return (base >= "a" && base <= "z") ? 7'(base & 8'h1F) : '0;
        end
        if (keys_down[LSHIFT_KEY] || keys_down[RSHIFT_KEY]) begin
            return US_UPPER[key[ROM_AW-1:0]][6:0];
        end
        return base[6:0];
    endfunction

    function automatic key_result_t predict_key_event(input logic cmd, input logic [7:0] code);
        key_result_t      res;
        logic [KEY_W-1:0] key;
        res = '0;
        key = code[KEY_W-1:0];
        if (cmd == CMD_SCANCODE) begin
            if (8'(ring_wr + 8'd1) == ring_rd) begin
                ring_rd = ring_rd + 8'd1;
            end
            ring_codes[ring_wr] = code;
            ring_wr = ring_wr + 8'd1;
            keys_down[key] = !code[RELEASE_BIT];
            if (!code[RELEASE_BIT]) begin
                res.kind  = EV_PRESS;
                res.ascii = layout_char(key);
            end else begin
                res.kind = EV_RELEASE;
            end
        end else if (ring_rd == ring_wr) begin
            res.empty = 1'b1;
        end else begin
            res.popped = ring_codes[ring_rd];
            ring_rd = ring_rd + 8'd1;
        end
        res.shift = keys_down[LSHIFT_KEY] | keys_down[RSHIFT_KEY];
        res.ctrl  = keys_down[CTRL_KEY];
        return res;
    endfunction

    task automatic add_request(input logic cmd, input logic [7:0] code,
                               input logic drain_first = 1'b0);
        key_request_t req;
        req.cmd         = cmd;
        req.code        = code;
        req.drain_first = drain_first;
        pending_requests.push_back(req);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : request_driver
        key_request_t req;
        logic         offer;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(predict_key_event(s_tuser, s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                offer = 1'b0;
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_requests.size() != 0 &&
                             !(pending_requests[0].drain_first &&
                               awaited_results.size() != 0)) begin
                    req = pending_requests.pop_front();
                    s_tdata <= req.code;
                    s_tuser <= req.cmd;
                    offer = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
                s_tvalid <= offer;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        key_result_t want;
        logic [15:0] next_pattern;
        next_pattern = {ready_pattern[0], ready_pattern[15:1]};
        if (pattern_age == 63) begin
            next_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            pattern_age <= 0;
        end else begin
            pattern_age <= pattern_age + 1;
        end
        ready_pattern <= next_pattern;
        m_tready      <= next_pattern[0];

        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("result with no request outstanding: tdata %0h, tuser %0h",
                       m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("ascii_char", 32'(want.ascii), 32'(m_tdata[6:0]));
                check_field("popped_code", 32'(want.popped), 32'(m_tdata[14:7]));
                check_field("shift_held", 32'(want.shift), 32'(m_tdata[15]));
                check_field("ctrl_held", 32'(want.ctrl), 32'(m_tdata[16]));
                check_field("tdata padding", 0, 32'(m_tdata[23:17]));
                check_field("event_kind", 32'(want.kind), 32'(m_tuser[1:0]));
                check_field("buffer_empty", 32'(want.empty), 32'(m_tuser[2]));
            end
        end
    end

    initial begin : stimulus
        int               mods;
        int               pop_cap;
        logic [KEY_W-1:0] key;
        logic [7:0]       shift_code;

        // Directed: empty pop, field extremes, plain, shifted and control presses.
        add_request(CMD_POP, 8'h00);
        add_request(CMD_SCANCODE, 8'h00);
        add_request(CMD_SCANCODE, 8'h7F);
        add_request(CMD_SCANCODE, 8'hFF);
        add_request(CMD_SCANCODE, 8'h1E);
        add_request(CMD_SCANCODE, 8'h02);
        add_request(CMD_SCANCODE, {1'b0, LSHIFT_KEY});
        add_request(CMD_SCANCODE, 8'h1E);
        add_request(CMD_SCANCODE, 8'h02);
        add_request(CMD_SCANCODE, {1'b1, LSHIFT_KEY});
        add_request(CMD_SCANCODE, {1'b0, RSHIFT_KEY});
        add_request(CMD_SCANCODE, 8'h10);
        add_request(CMD_SCANCODE, {1'b1, RSHIFT_KEY});
        add_request(CMD_SCANCODE, {1'b0, CTRL_KEY});
        add_request(CMD_SCANCODE, 8'h1E);
        add_request(CMD_SCANCODE, 8'h02);
        add_request(CMD_SCANCODE, {1'b0, LSHIFT_KEY});
        add_request(CMD_SCANCODE, 8'h2C);
        add_request(CMD_SCANCODE, {1'b1, CTRL_KEY});
        add_request(CMD_SCANCODE, {1'b1, LSHIFT_KEY});
        add_request(CMD_SCANCODE, 8'h39);
        add_request(CMD_SCANCODE, 8'h3A);
        add_request(CMD_POP, 8'hFF);
        add_request(CMD_POP, 8'h00);
        add_request(CMD_POP, 8'h5A);

        // Overrun the buffer so the oldest codes are dropped, then drain it past empty.
        for (int i = 0; i < 300; i++) begin
            add_request(CMD_SCANCODE, 8'($urandom_range(0, 255)), i == 0);
        end
        for (int i = 0; i < 262; i++) begin
            add_request(CMD_POP, 8'($urandom_range(0, 255)));
        end

        pop_cap = 2;
        for (int seq = 0; pending_requests.size() < 1400; seq++) begin
            if (seq % 20 == 0) begin
                pop_cap = $urandom_range(0, 8);
            end
            if ($urandom_range(0, 7) == 0) begin
                add_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), seq == 0);
                continue;
            end
            mods       = $urandom_range(0, 3);
            shift_code = {1'b0, ($urandom_range(0, 1) != 0) ? LSHIFT_KEY : RSHIFT_KEY};
            if (mods[0]) begin
                add_request(CMD_SCANCODE, shift_code, seq == 0);
            end
            if (mods[1]) begin
                add_request(CMD_SCANCODE, {1'b0, CTRL_KEY}, seq == 0 && !mods[0]);
            end
            key = ($urandom_range(0, 5) == 0) ? KEY_W'($urandom_range(0, 127))
                                              : KEY_W'($urandom_range(0, LAYOUT_KEYS - 1));
            repeat ($urandom_range(1, 3)) begin
                add_request(CMD_SCANCODE, {1'b0, key}, seq == 0 && mods == 0);
            end
            add_request(CMD_SCANCODE, {1'b1, key});
            if (mods[1] && $urandom_range(0, 3) != 0) begin
                add_request(CMD_SCANCODE, {1'b1, CTRL_KEY});
            end
            if (mods[0] && $urandom_range(0, 3) != 0) begin
                add_request(CMD_SCANCODE, shift_code | 8'h80);
            end
            repeat ($urandom_range(0, pop_cap)) begin
                add_request(CMD_POP, 8'($urandom_range(0, 255)));
            end
        end

        while (pending_requests.size() != 0 || s_tvalid || awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/kscfe_pkg.sv
design/kscfe_ram.sv
design/kscfe_ring.sv
design/kscfe_xlate.sv
design/keyboard_scancode_front_end.sv
sim/testbench.sv
